// ----- design/sar_pkg.sv -----
// ----------------------------------------------------------------------------
// sar_pkg - shared types and constants for the stick auto-repeat block
// Register map, reset values and the configuration and pulse structs.
// ----------------------------------------------------------------------------
package sar_pkg;

   localparam int StickW    = 12;
   localparam int IntervalW = 16;
   localparam int TimeW     = 32;
   localparam int CsrDataW  = 32;
   localparam int CsrAddrW  = 5;
   localparam int CsrIdxW   = 3;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [CsrIdxW-1:0] {
      REG_INITIAL_INTERVAL = 3'd0,
      REG_LONG_INTERVAL    = 3'd1,
      REG_MIN_INTERVAL     = 3'd2,
      REG_SPEEDUP_STEP     = 3'd3,
      REG_HIGH_THRESHOLD   = 3'd4,
      REG_LOW_THRESHOLD    = 3'd5
   } reg_idx_type;

   localparam logic [IntervalW-1:0] RST_INITIAL_INTERVAL = 16'd300;
   localparam logic [IntervalW-1:0] RST_LONG_INTERVAL    = 16'd1000;
   localparam logic [IntervalW-1:0] RST_MIN_INTERVAL     = 16'd50;
   localparam logic [IntervalW-1:0] RST_SPEEDUP_STEP     = 16'd50;
   localparam logic [StickW-1:0]    RST_HIGH_THRESHOLD   = 12'd1750;
   localparam logic [StickW-1:0]    RST_LOW_THRESHOLD    = 12'd250;

   typedef struct packed {
      logic [IntervalW-1:0] initial_interval;
      logic [IntervalW-1:0] long_interval;
      logic [IntervalW-1:0] min_interval;
      logic [IntervalW-1:0] speedup_step;
      logic [StickW-1:0]    high_threshold;
      logic [StickW-1:0]    low_threshold;
   } cfg_type;

   // Direction pulse of one channel
   typedef struct packed {
      logic lo;
      logic hi;
   } pulse_type;

endpackage

// ----- design/sar_if.sv -----
// ----------------------------------------------------------------------------
// sar_req_if / sar_rsp_if - valid/ready channels of the stick auto-repeat block
// One sample word in, one pulse word out.
// ----------------------------------------------------------------------------
interface sar_req_if;
   logic                         valid;
   logic                         ready;
   logic [sar_pkg::StickW-1:0]   roll_value;
   logic [sar_pkg::StickW-1:0]   pitch_value;
   logic [sar_pkg::StickW-1:0]   yaw_value;
   logic                         is_armed;
   logic [sar_pkg::TimeW-1:0]    now_ms;

   modport source (output valid, roll_value, pitch_value, yaw_value, is_armed, now_ms,
                   input ready);
   modport sink   (input valid, roll_value, pitch_value, yaw_value, is_armed, now_ms,
                   output ready);
endinterface

interface sar_rsp_if;
   logic valid;
   logic ready;
   logic roll_lo_pulse;
   logic roll_hi_pulse;
   logic pitch_lo_pulse;
   logic pitch_hi_pulse;
   logic yaw_lo_pulse;
   logic yaw_hi_pulse;
   logic yawlong_lo_pulse;
   logic yawlong_hi_pulse;

   modport source (output valid, roll_lo_pulse, roll_hi_pulse, pitch_lo_pulse, pitch_hi_pulse,
                   yaw_lo_pulse, yaw_hi_pulse, yawlong_lo_pulse, yawlong_hi_pulse,
                   input ready);
   modport sink   (input valid, roll_lo_pulse, roll_hi_pulse, pitch_lo_pulse, pitch_hi_pulse,
                   yaw_lo_pulse, yaw_hi_pulse, yawlong_lo_pulse, yawlong_hi_pulse,
                   output ready);
endinterface

// ----- design/sar_chan.sv -----
// ----------------------------------------------------------------------------
// sar_chan - one auto-repeat channel
// Holds held flag, press time and current interval; gives a direction pulse.
// ----------------------------------------------------------------------------
module sar_chan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,       // disarmed sample this cycle
   input  logic                          long_chan,  // tied: long-yaw behavior
   input  logic [sar_pkg::StickW-1:0]    value,
   input  logic [sar_pkg::TimeW-1:0]     now_ms,
   input  sar_pkg::cfg_type              cfg,
   output sar_pkg::pulse_type            pulse
);

   logic                            held_ff, held_in;
   logic [sar_pkg::TimeW-1:0]       press_ff, press_in;
   logic [sar_pkg::IntervalW-1:0]   interval_ff, interval_in;

   logic                            high, low, fire;
   logic [sar_pkg::TimeW-1:0]       elapsed;
   logic [sar_pkg::IntervalW-1:0]   first_interval, reset_interval;

   assign high           = value > cfg.high_threshold;
   assign low            = value < cfg.low_threshold;
   assign elapsed        = now_ms - press_ff;
   assign first_interval = long_chan ? cfg.long_interval : cfg.initial_interval;
   assign reset_interval = long_chan ? sar_pkg::RST_LONG_INTERVAL
                                     : sar_pkg::RST_INITIAL_INTERVAL;

   always_comb begin
      held_in     = held_ff;
      press_in    = press_ff;
      interval_in = interval_ff;
      fire        = 1'b0;
      if (high || low) begin
         if (!held_ff) begin
            held_in  = 1'b1;
            press_in = now_ms;
            fire     = !long_chan;
         end else if (elapsed > {{(sar_pkg::TimeW-sar_pkg::IntervalW){1'b0}}, interval_ff}) begin
            if (interval_ff > cfg.min_interval) begin
               // shrink, saturating at zero
               if (interval_ff > cfg.speedup_step) begin
                  interval_in = interval_ff - cfg.speedup_step;
               end else begin
                  interval_in = '0;
               end
            end
            fire     = 1'b1;
            press_in = now_ms;
         end
      end else begin
         held_in = 1'b0;
      end
      if (!held_in) begin
         interval_in = first_interval;
      end
   end

   // high wins when both thresholds trip
   assign pulse.hi = step && fire && high;
   assign pulse.lo = step && fire && !high;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= 1'b0;
         press_ff    <= '0;
         interval_ff <= reset_interval;
      end else if (step) begin
         held_ff     <= held_in;
         press_ff    <= press_in;
         interval_ff <= interval_in;
      end
   end

endmodule

// ----- design/stick_autorepeat_accel.sv -----
// ----------------------------------------------------------------------------
// stick_autorepeat_accel - typematic auto-repeat with acceleration, 3 sticks
// Four repeat channels (roll, pitch, yaw, long-yaw) turn stick samples into
// direction pulses that speed up while a stick is held.
// ----------------------------------------------------------------------------
//  channel | dir | word                                   | handshake
//  --------+-----+----------------------------------------+-----------------
//  req_bus | in  | roll/pitch/yaw value, is_armed, now_ms | valid/ready
//  rsp_bus | out | eight direction pulse bits             | valid/ready
//  APB     | in  | six config registers at 4*index        | psel/penable
//
//  One sample word per clock while rsp_bus.ready stays high; the path is the
//  input register, then channel logic into the result register.
//  Channel state is read and updated in the result stage only, so samples
//  follow each other without bubbles.
//  Synchronous active-high reset clears channel state and loads register
//  defaults. A stalled result holds both stages; req_bus.ready drops only
//  when both are full and rsp_bus.ready is low.
// ----------------------------------------------------------------------------
module stick_autorepeat_accel (
   input  logic                            clock,
   input  logic                            reset,
   sar_req_if.sink                         req_bus,
   sar_rsp_if.source                       rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sar_pkg::CsrAddrW-1:0]    paddr,
   input  logic [sar_pkg::CsrDataW-1:0]    pwdata,
   output logic [sar_pkg::CsrDataW-1:0]    prdata,
   output logic                            pready
);

   // ---------------------------------------------------------------- config
   sar_pkg::cfg_type              cfg_ff;
   logic                          cfg_wr;
   sar_pkg::reg_idx_type          cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = sar_pkg::reg_idx_type'(paddr[sar_pkg::CsrAddrW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_interval <= sar_pkg::RST_INITIAL_INTERVAL;
         cfg_ff.long_interval    <= sar_pkg::RST_LONG_INTERVAL;
         cfg_ff.min_interval     <= sar_pkg::RST_MIN_INTERVAL;
         cfg_ff.speedup_step     <= sar_pkg::RST_SPEEDUP_STEP;
         cfg_ff.high_threshold   <= sar_pkg::RST_HIGH_THRESHOLD;
         cfg_ff.low_threshold    <= sar_pkg::RST_LOW_THRESHOLD;
      end else if (cfg_wr) begin
         // indexes past the map fall through and are dropped
         unique case (cfg_idx)
            sar_pkg::REG_INITIAL_INTERVAL: cfg_ff.initial_interval <= pwdata[15:0];
            sar_pkg::REG_LONG_INTERVAL:    cfg_ff.long_interval    <= pwdata[15:0];
            sar_pkg::REG_MIN_INTERVAL:     cfg_ff.min_interval     <= pwdata[15:0];
            sar_pkg::REG_SPEEDUP_STEP:     cfg_ff.speedup_step     <= pwdata[15:0];
            sar_pkg::REG_HIGH_THRESHOLD:   cfg_ff.high_threshold   <= pwdata[11:0];
            sar_pkg::REG_LOW_THRESHOLD:    cfg_ff.low_threshold    <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (cfg_idx)
         sar_pkg::REG_INITIAL_INTERVAL: prdata[15:0] = cfg_ff.initial_interval;
         sar_pkg::REG_LONG_INTERVAL:    prdata[15:0] = cfg_ff.long_interval;
         sar_pkg::REG_MIN_INTERVAL:     prdata[15:0] = cfg_ff.min_interval;
         sar_pkg::REG_SPEEDUP_STEP:     prdata[15:0] = cfg_ff.speedup_step;
         sar_pkg::REG_HIGH_THRESHOLD:   prdata[11:0] = cfg_ff.high_threshold;
         sar_pkg::REG_LOW_THRESHOLD:    prdata[11:0] = cfg_ff.low_threshold;
         default: ;
      endcase
   end

   // ---------------------------------------------------------- input stage
   logic                            s1_valid_ff;
   logic [sar_pkg::StickW-1:0]      s1_roll_ff, s1_pitch_ff, s1_yaw_ff;
   logic                            s1_armed_ff;
   logic [sar_pkg::TimeW-1:0]       s1_now_ff;

   logic                            rsp_valid_ff;
   logic [7:0]                      rsp_bits_ff, rsp_bits_in;

   logic                            advance;   // result stage free this cycle
   logic                            step;      // disarmed sample updates state

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign step          = s1_valid_ff && advance && !s1_armed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_roll_ff  <= req_bus.roll_value;
         s1_pitch_ff <= req_bus.pitch_value;
         s1_yaw_ff   <= req_bus.yaw_value;
         s1_armed_ff <= req_bus.is_armed;
         s1_now_ff   <= req_bus.now_ms;
      end
   end

   // -------------------------------------------------------------- channels
   sar_pkg::pulse_type roll_p, pitch_p, yaw_p, long_p;

   sar_chan u_roll (
      .clock(clock), .reset(reset), .step(step), .long_chan(1'b0),
      .value(s1_roll_ff), .now_ms(s1_now_ff), .cfg(cfg_ff), .pulse(roll_p));

   sar_chan u_pitch (
      .clock(clock), .reset(reset), .step(step), .long_chan(1'b0),
      .value(s1_pitch_ff), .now_ms(s1_now_ff), .cfg(cfg_ff), .pulse(pitch_p));

   sar_chan u_yaw (
      .clock(clock), .reset(reset), .step(step), .long_chan(1'b0),
      .value(s1_yaw_ff), .now_ms(s1_now_ff), .cfg(cfg_ff), .pulse(yaw_p));

   // long-yaw watches the same yaw stick, no pulse on first deflection
   sar_chan u_long (
      .clock(clock), .reset(reset), .step(step), .long_chan(1'b1),
      .value(s1_yaw_ff), .now_ms(s1_now_ff), .cfg(cfg_ff), .pulse(long_p));

   // pulses are gated by step, so an armed sample yields all zeros
   assign rsp_bits_in = {long_p.hi, long_p.lo, yaw_p.hi, yaw_p.lo,
                         pitch_p.hi, pitch_p.lo, roll_p.hi, roll_p.lo};

   // --------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_bits_ff <= rsp_bits_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.roll_lo_pulse    = rsp_bits_ff[0];
   assign rsp_bus.roll_hi_pulse    = rsp_bits_ff[1];
   assign rsp_bus.pitch_lo_pulse   = rsp_bits_ff[2];
   assign rsp_bus.pitch_hi_pulse   = rsp_bits_ff[3];
   assign rsp_bus.yaw_lo_pulse     = rsp_bits_ff[4];
   assign rsp_bus.yaw_hi_pulse     = rsp_bits_ff[5];
   assign rsp_bus.yawlong_lo_pulse = rsp_bits_ff[6];
   assign rsp_bus.yawlong_hi_pulse = rsp_bits_ff[7];

   // ------------------------------------------------------------ assertions
   a_armed_quiet: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance && s1_armed_ff |=> rsp_bits_ff == 8'd0)
      else $error("armed sample produced a pulse");

   a_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_bits_ff[0] && rsp_bits_ff[1]) &&
                       !(rsp_bits_ff[2] && rsp_bits_ff[3]) &&
                       !(rsp_bits_ff[4] && rsp_bits_ff[5]) &&
                       !(rsp_bits_ff[6] && rsp_bits_ff[7]))
      else $error("both directions pulsed on one channel");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_bus.ready)
      else $error("input stalled with room in the pipeline");

   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      cfg_wr && cfg_idx == sar_pkg::REG_INITIAL_INTERVAL
      |=> cfg_ff.initial_interval == $past(pwdata[15:0]))
      else $error("initial interval write lost");

endmodule

// ----- tb/autorepeat_checker.sv -----
// ----------------------------------------------------------------------------
// autorepeat_checker - scoreboard for the stick auto-repeat block
// Snoops both channels and the APB port, predicts the pulse word for every
// accepted sample and compares it bit by bit with what comes out.
// ----------------------------------------------------------------------------
module autorepeat_checker (
   input  logic                         clock,
   input  logic                         reset,
   sar_req_if                           req_bus,
   sar_rsp_if                           rsp_bus,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sar_pkg::CsrAddrW-1:0] paddr,
   input  logic [sar_pkg::CsrDataW-1:0] pwdata,
   input  logic [sar_pkg::CsrDataW-1:0] prdata,
   input  logic                         pready,
   output int                           fail_count,
   output int                           pending
);
   import sar_pkg::*;

   localparam int NumChannels = 4;
   localparam int WordBits    = 8;
   localparam int MaxReports  = 200;

   typedef enum int {CH_ROLL, CH_PITCH, CH_YAW, CH_YAW_LONG} channel_type;

   // bit 7 = roll_lo_pulse ... bit 0 = yawlong_hi_pulse
   typedef struct packed {
      pulse_type roll;
      pulse_type pitch;
      pulse_type yaw;
      pulse_type yaw_long;
   } pulse_word_type;

   string field_name [0:WordBits-1] = '{"roll_lo_pulse", "roll_hi_pulse", "pitch_lo_pulse",
      "pitch_hi_pulse", "yaw_lo_pulse", "yaw_hi_pulse", "yawlong_lo_pulse",
      "yawlong_hi_pulse"};

   cfg_type              csr_shadow;
   logic                 held        [NumChannels];
   logic [TimeW-1:0]     press_ms    [NumChannels];
   logic [IntervalW-1:0] interval_ms [NumChannels];
   pulse_word_type       expected_pulses [$];

   function automatic logic [IntervalW-1:0] first_interval(channel_type ch);
      return (ch == CH_YAW_LONG) ? csr_shadow.long_interval : csr_shadow.initial_interval;
   endfunction

   // One repeat channel; high deflection wins when both thresholds trip.
   function automatic pulse_type advance_channel(channel_type ch, logic [StickW-1:0] value,
                                                 logic [TimeW-1:0] now, bit skip_first);
      pulse_type        pulse;
      logic             is_high;
      logic             is_low;
      logic [TimeW-1:0] elapsed;
      pulse   = '0;
      is_high = value > csr_shadow.high_threshold;
      is_low  = value < csr_shadow.low_threshold;
      elapsed = now - press_ms[ch];
      if (is_high || is_low) begin
         if (!held[ch]) begin
            held[ch]     = 1'b1;
            press_ms[ch] = now;
            if (!skip_first) begin
               pulse.hi = is_high;
               pulse.lo = !is_high;
            end
         end else if (elapsed > TimeW'(interval_ms[ch])) begin
            if (interval_ms[ch] > csr_shadow.min_interval) begin
               if (interval_ms[ch] > csr_shadow.speedup_step)
                  interval_ms[ch] = interval_ms[ch] - csr_shadow.speedup_step;
               else
                  interval_ms[ch] = '0;
            end
            pulse.hi     = is_high;
            pulse.lo     = !is_high;
            press_ms[ch] = now;
         end
      end else begin
         held[ch] = 1'b0;
      end
      if (!held[ch])
         interval_ms[ch] = first_interval(ch);
      return pulse;
   endfunction

   function automatic pulse_word_type predict_pulses();
      pulse_word_type word;
      word = '0;
      if (!req_bus.is_armed) begin
         word.roll     = advance_channel(CH_ROLL, req_bus.roll_value, req_bus.now_ms, 1'b0);
         word.pitch    = advance_channel(CH_PITCH, req_bus.pitch_value, req_bus.now_ms, 1'b0);
         word.yaw      = advance_channel(CH_YAW, req_bus.yaw_value, req_bus.now_ms, 1'b0);
         word.yaw_long = advance_channel(CH_YAW_LONG, req_bus.yaw_value, req_bus.now_ms, 1'b1);
      end
      return word;
   endfunction

   function automatic logic [CsrDataW-1:0] shadow_value(reg_idx_type idx);
      case (idx)
         REG_INITIAL_INTERVAL: return CsrDataW'(csr_shadow.initial_interval);
         REG_LONG_INTERVAL:    return CsrDataW'(csr_shadow.long_interval);
         REG_MIN_INTERVAL:     return CsrDataW'(csr_shadow.min_interval);
         REG_SPEEDUP_STEP:     return CsrDataW'(csr_shadow.speedup_step);
         REG_HIGH_THRESHOLD:   return CsrDataW'(csr_shadow.high_threshold);
         default:              return CsrDataW'(csr_shadow.low_threshold);
      endcase
   endfunction

   task automatic report(string what, logic [CsrDataW-1:0] want, logic [CsrDataW-1:0] got);
      if (fail_count < MaxReports)
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      reg_idx_type    idx;
      pulse_word_type want;
      pulse_word_type got;
      if (reset) begin
         csr_shadow.initial_interval = RST_INITIAL_INTERVAL;
         csr_shadow.long_interval    = RST_LONG_INTERVAL;
         csr_shadow.min_interval     = RST_MIN_INTERVAL;
         csr_shadow.speedup_step     = RST_SPEEDUP_STEP;
         csr_shadow.high_threshold   = RST_HIGH_THRESHOLD;
         csr_shadow.low_threshold    = RST_LOW_THRESHOLD;
         for (int ch = 0; ch < NumChannels; ch++) begin
            held[ch]        = 1'b0;
            press_ms[ch]    = '0;
            interval_ms[ch] = first_interval(channel_type'(ch));
         end
         expected_pulses.delete();
         pending <= 0;
      end else begin
         idx = reg_idx_type'(paddr[CsrAddrW-1:2]);
         if (psel && penable && pready && pwrite) begin
            case (idx)
               REG_INITIAL_INTERVAL: csr_shadow.initial_interval = pwdata[IntervalW-1:0];
               REG_LONG_INTERVAL:    csr_shadow.long_interval    = pwdata[IntervalW-1:0];
               REG_MIN_INTERVAL:     csr_shadow.min_interval     = pwdata[IntervalW-1:0];
               REG_SPEEDUP_STEP:     csr_shadow.speedup_step     = pwdata[IntervalW-1:0];
               REG_HIGH_THRESHOLD:   csr_shadow.high_threshold   = pwdata[StickW-1:0];
               REG_LOW_THRESHOLD:    csr_shadow.low_threshold    = pwdata[StickW-1:0];
               default: ;
            endcase
         end
         if (psel && penable && pready && !pwrite && idx <= REG_LOW_THRESHOLD) begin
            if (prdata !== shadow_value(idx))
               report($sformatf("register %s", idx.name()), shadow_value(idx), prdata);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.roll_lo_pulse, rsp_bus.roll_hi_pulse, rsp_bus.pitch_lo_pulse,
                   rsp_bus.pitch_hi_pulse, rsp_bus.yaw_lo_pulse, rsp_bus.yaw_hi_pulse,
                   rsp_bus.yawlong_lo_pulse, rsp_bus.yawlong_hi_pulse};
            if (expected_pulses.size() == 0) begin
               report("unexpected pulse word", '0, CsrDataW'(got));
            end else begin
               want = expected_pulses.pop_front();
               for (int i = 0; i < WordBits; i++) begin
                  if (got[WordBits-1-i] !== want[WordBits-1-i])
                     report(field_name[i], CsrDataW'(want[WordBits-1-i]),
                            CsrDataW'(got[WordBits-1-i]));
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_pulses.push_back(predict_pulses());
         pending <= expected_pulses.size();
      end
   end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for stick_autorepeat_accel
// Directed samples on the reset settings, then random stick sequences under
// several register settings, with random gaps and stalls on both channels.
// The checker beside the block predicts and compares every pulse word.
// ----------------------------------------------------------------------------
module testbench;
   import sar_pkg::*;

   localparam int CycleLimit = 500000;
   localparam int DrainCycles = 4;      // drain wait after the last pulse word
   localparam int HoldOffAt = 250;      // words sent before the long stall
   localparam int HoldOffCycles = 120;
   localparam logic [StickW-1:0] StickMax = {StickW{1'b1}};
   localparam logic [StickW-1:0] StickMid = StickW'(2048);

   // Stick position a random axis is steered into for a run of samples
   typedef enum int {POS_CENTER, POS_LOW, POS_HIGH, POS_NOISE} stick_pos_type;

   logic clock = 1'b0;
   logic reset;

   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [CsrDataW-1:0] pwdata;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   int fail_count;
   int pending;
   int words_sent = 0;
   int cycle_count = 0;
   bit held_off = 1'b0;

   // Thresholds currently programmed; random sticks aim around them
   logic [StickW-1:0] cur_high = RST_HIGH_THRESHOLD;
   logic [StickW-1:0] cur_low  = RST_LOW_THRESHOLD;
   logic [TimeW-1:0]  sample_ms;

   // Per-axis run state: roll, pitch, yaw
   stick_pos_type axis_pos [3];
   int            axis_run [3] = '{0, 0, 0};

   sar_req_if req_bus ();
   sar_rsp_if rsp_bus ();

   stick_autorepeat_accel u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   autorepeat_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   // --- APB --------------------------------------------------------------
   // psel stays high across back-to-back transfers; only penable drops for
   // the setup phase. csr_release ends a burst.
   task automatic csr_access(input logic [CsrIdxW-1:0] idx, input bit is_write,
                             input logic [CsrDataW-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic csr_release();
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Program all six registers, optionally poke the unmapped slots (must be
   // ignored), then read everything back; the checker compares the reads.
   task automatic configure(input logic [IntervalW-1:0] init_ms, long_ms, min_ms, step_ms,
                            input logic [StickW-1:0] high, low, input bit poke_unused);
      csr_access(REG_INITIAL_INTERVAL, 1'b1, CsrDataW'(init_ms));
      csr_access(REG_LONG_INTERVAL,    1'b1, CsrDataW'(long_ms));
      csr_access(REG_MIN_INTERVAL,     1'b1, CsrDataW'(min_ms));
      csr_access(REG_SPEEDUP_STEP,     1'b1, CsrDataW'(step_ms));
      csr_access(REG_HIGH_THRESHOLD,   1'b1, CsrDataW'(high));
      csr_access(REG_LOW_THRESHOLD,    1'b1, CsrDataW'(low));
      if (poke_unused) begin
         csr_access(CsrIdxW'(REG_LOW_THRESHOLD + 1), 1'b1, $urandom());
         csr_access(CsrIdxW'(REG_LOW_THRESHOLD + 2), 1'b1, $urandom());
      end
      for (int i = 0; i <= REG_LOW_THRESHOLD; i++)
         csr_access(CsrIdxW'(i), 1'b0, '0);
      csr_release();
      cur_high = high;
      cur_low  = low;
   endtask

   // --- sample channel -----------------------------------------------------
   // valid is never lowered here; idle_req drops it only for a real gap, so
   // back-to-back words see a single assignment per step.
   task automatic send_sample(input logic [StickW-1:0] roll, pitch, yaw,
                              input logic armed, input logic [TimeW-1:0] now);
      req_bus.valid       <= 1'b1;
      req_bus.roll_value  <= roll;
      req_bus.pitch_value <= pitch;
      req_bus.yaw_value   <= yaw;
      req_bus.is_armed    <= armed;
      req_bus.now_ms      <= now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic idle_req(input int cycles);
      if (cycles > 0) begin
         req_bus.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Block goes quiet: drop valid, wait until every pulse word is back,
   // then wait DrainCycles more before any register write.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Millisecond advance per sample: mostly small so held sticks ripen into
   // repeats, sometimes big enough for the 64k intervals, rarely a jump
   // anywhere (wrap, all time bits).
   function automatic logic [TimeW-1:0] next_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 12);
      if (r < 80) return $urandom_range(0, 100);
      if (r < 93) return $urandom_range(100, 3000);
      if (r < 97) return $urandom_range(60000, 70000);
      return $urandom();
   endfunction

   function automatic logic [StickW-1:0] pick_value(stick_pos_type pos);
      case (pos)
         POS_LOW: begin
            if (cur_low == '0 || $urandom_range(0, 7) == 0) return '0;
            return StickW'($urandom_range(0, cur_low - 1));
         end
         POS_HIGH: begin
            if (cur_high == StickMax || $urandom_range(0, 7) == 0) return StickMax;
            return StickW'($urandom_range(cur_high + 1, StickMax));
         end
         POS_CENTER: begin
            if (cur_low <= cur_high) return StickW'($urandom_range(cur_low, cur_high));
            return StickW'($urandom());
         end
         default: begin
            if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? StickMax : '0;
            return StickW'($urandom());
         end
      endcase
   endfunction

   // Random sticks: each axis holds a position for a run of samples, so
   // presses, repeats and releases dominate; noise runs are short.
   task automatic run_phase(input int count);
      logic [StickW-1:0] value [3];
      logic              armed;
      int                armed_run;
      bit                no_gaps;
      int                r;
      armed_run = 0;
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) begin
         for (int a = 0; a < 3; a++) begin
            if (axis_run[a] == 0) begin
               r = $urandom_range(0, 99);
               axis_pos[a] = (r < 30) ? POS_CENTER : (r < 60) ? POS_LOW :
                             (r < 90) ? POS_HIGH : POS_NOISE;
               axis_run[a] = (axis_pos[a] == POS_NOISE) ? $urandom_range(1, 5)
                                                        : $urandom_range(1, 40);
            end
            value[a] = pick_value(axis_pos[a]);
            axis_run[a]--;
         end
         if (armed_run > 0) begin
            armed_run--;
            armed = 1'b1;
         end else begin
            armed = 1'b0;
            if ($urandom_range(0, 24) == 0) armed_run = $urandom_range(1, 6);
         end
         if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
         sample_ms = sample_ms + next_step();
         send_sample(value[0], value[1], value[2], armed, sample_ms);
         idle_req(no_gaps ? 0 : pick_gap());
      end
   endtask

   // --- result channel back-pressure -------------------------------------
   // One long hold-off mid-run so the block fills and drops req ready;
   // otherwise short/long stalls and stall-free stretches.
   initial begin
      int r;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && words_sent >= HoldOffAt) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_bus.ready <= 1'b1;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end else if (r < 85) begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else if (r < 93) begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(8, 30)) @(posedge clock);
            end else begin
               rsp_bus.ready <= 1'b1;
               repeat ($urandom_range(50, 150)) @(posedge clock);
            end
         end
      end
   end

   // --- watchdog -----------------------------------------------------------
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   // --- main sequence -------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.roll_value  <= '0;
      req_bus.pitch_value <= '0;
      req_bus.yaw_value   <= '0;
      req_bus.is_armed    <= 1'b0;
      req_bus.now_ms      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings (300/1000 ms, step 50, thresholds 1750/250)
      send_sample(StickMid, StickMid, StickMid, 1'b0, 32'd1000);  // 2048 is above 1750: first pulses
      send_sample('0, StickMax, StickMax, 1'b0, 32'd1010);        // held, no repeat yet
      send_sample('0, StickMax, StickMax, 1'b0, 32'd1310);        // elapsed 310 > 300: repeat, shrink
      send_sample('0, StickMax, StickMax, 1'b0, 32'd1311);        // elapsed 1: no repeat
      idle_req(pick_gap());
      send_sample('0, StickMax, StickMax, 1'b1, 32'd9000);        // armed: frozen, silent
      send_sample('0, StickMax, StickMax, 1'b0, 32'd1562);        // repeat again
      send_sample('0, StickMax, StickMax, 1'b0, 32'd2011);        // long-yaw repeat
      send_sample(12'd249, 12'd1751, 12'd1750, 1'b0, 32'd2012);   // edges; yaw lets go
      send_sample(12'd250, 12'd1750, 12'd251, 1'b0, 32'd2013);    // all released
      idle_req(pick_gap());
      send_sample(StickMax, '0, '0, 1'b0, 32'hFFFF_FFF0);         // press just before wrap
      send_sample(StickMax, '0, '0, 1'b0, 32'h0000_0200);         // elapsed across wrap
      send_sample(StickMax, '0, '0, 1'b1, 32'h0000_0300);
      send_sample(StickMax, '0, '0, 1'b0, 32'h0000_0700);         // long-yaw over wrap
      send_sample(StickMid, StickMid, StickMid, 1'b0, 32'h0000_0701);
      sample_ms = 32'h0000_0701;
      settle();

      // Fast repeats with real shrinking
      configure(16'd20, 16'd60, 16'd4, 16'd3, 12'd3000, 12'd1000, 1'b0);
      run_phase(220);
      settle();

      // All-zero extremes: zero interval, anything above 0 is high
      configure('0, '0, '0, '0, '0, '0, 1'b0);
      run_phase(200);
      settle();

      // All-ones extremes: no shrink, nearly every value counts as low
      configure('1, '1, '1, '1, StickMax, StickMax, 1'b0);
      run_phase(200);
      settle();

      // Overlapping thresholds (high wins), step past interval saturates to 0,
      // plus writes to unmapped slots that must be ignored
      configure(16'd30, 16'd90, '0, 16'd40, 12'd1500, 12'd2500, 1'b1);
      run_phase(220);
      settle();

      for (int p = 0; p < 3; p++) begin
         configure(IntervalW'($urandom_range(0, 80)), IntervalW'($urandom_range(0, 240)),
                   IntervalW'($urandom_range(0, 20)), IntervalW'($urandom_range(0, 30)),
                   StickW'($urandom_range(0, StickMax)),
                   StickW'($urandom_range(0, StickMax)), p[0]);
         run_phase(230);
         settle();
      end

      if (fail_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
